/* src/xoro_pkg.sv */
// Package for the xoroshiro128++ generator: op codes, queue item type and
// the SplitMix64 / xoroshiro constants. No dependencies.
package xoro_pkg;

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_DRAW32 = 2'd1;
  localparam logic [1:0] OP_DRAW53 = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam int VALUE_W     = 53;
  localparam int FRAC_SHIFT  = 11;

  localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_ONE = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_TWO = 64'h94D049BB133111EB;
  localparam logic [63:0] RESET_A     = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] RESET_B     = 64'hBF58476D1CE4E5B9;

  typedef enum logic [1:0] {
    KIND_RESEED,
    KIND_DRAW32,
    KIND_DRAW53
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [31:0] seed;
  } q_head_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int amt);
    return (v << amt) | (v >> (64 - amt));
  endfunction

endpackage

/* src/xoroshiro128pp_generator_core.sv */
// Draw path: an accepted command is written into the queue, then the generator
// takes it from the queue head and registers the result; draws sustain one per
// cycle while the result side keeps up and no reseed is running.
// A reseed holds the generator while it loads, then for 12 steps of the
// shared 32x32 multiplier (two SplitMix64 rounds of two 64-bit products each).
// Reset: state words load their fixed seeds, queue empties, no result pending.
module xoroshiro128pp_generator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [1:0]                   op,
  input  logic [31:0]                  seed,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [xoro_pkg::VALUE_W-1:0] value
);
  import xoro_pkg::*;

  q_head_t head;
  logic    pop;

  xoro_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .op        (op),
    .seed      (seed),
    .head      (head),
    .pop       (pop)
  );

  xoro_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value)
  );

endmodule

/* src/xoro_front.sv */
// Front end: accepts command items, drops the unused op code and queues the
// rest in a two-entry queue for the back end. Uses xoro_pkg.
module xoro_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        op,
  input  logic [31:0]       seed,
  output xoro_pkg::q_head_t head,
  input  logic              pop
);
  import xoro_pkg::*;

  kind_t       q_kind [2];
  logic [31:0] q_seed [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  q_count;
  logic        push;
  kind_t       in_kind;

  assign cmd_stall = (q_count == 2'd2);
  assign push      = cmd_valid && !cmd_stall && (op != OP_NONE);

  always_comb begin
    unique case (op)
      OP_RESEED: in_kind = KIND_RESEED;
      OP_DRAW32: in_kind = KIND_DRAW32;
      default:   in_kind = KIND_DRAW53;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr] <= in_kind;
      q_seed[wr_ptr] <= seed;
    end
  end

  assign head.valid = (q_count != 2'd0);
  assign head.kind  = q_kind[rd_ptr];
  assign head.seed  = q_seed[rd_ptr];

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> q_count != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

/* src/xoro_back.sv */
// Back end: holds the generator state, steps it combinationally for draws and reseeds
// through a sequenced 32x32 multiplier; drives the result register. Uses xoro_pkg.
module xoro_back (
  input  logic                         clk,
  input  logic                         rst,
  input  xoro_pkg::q_head_t            head,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [xoro_pkg::VALUE_W-1:0] value
);
  import xoro_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MIX  = 2'b10
  } state_t;

  state_t      state;
  logic [63:0] word_a;
  logic [63:0] word_b;
  logic [63:0] mix_sum;
  logic [63:0] mix_x;
  logic [63:0] mix_acc;
  logic [1:0]  mix_step;
  logic        mix_sel;
  logic        mix_word;

  logic        out_free;
  logic        take_draw;
  logic        take_seed;
  logic [63:0] sum_ab;
  logic [63:0] draw_out;
  logic [63:0] draw_t;
  logic [63:0] draw_a;
  logic [63:0] draw_b;
  logic [63:0] seed_start;
  logic [63:0] seed_sum;
  logic [63:0] next_sum;
  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] acc_sum;
  logic [63:0] mix_mid;
  logic [63:0] mix_res;
  logic        last_step;

  assign out_free  = !res_valid || !res_stall;
  assign take_draw = (state == ST_IDLE) && head.valid && (head.kind != KIND_RESEED) && out_free;
  assign take_seed = (state == ST_IDLE) && head.valid && (head.kind == KIND_RESEED);
  assign pop       = take_draw || take_seed;

  // xoroshiro128++ step
  assign sum_ab   = word_a + word_b;
  assign draw_out = rotl64(sum_ab, 17) + word_a;
  assign draw_t   = word_b ^ word_a;
  assign draw_a   = rotl64(word_a, 49) ^ draw_t ^ (draw_t << 21);
  assign draw_b   = rotl64(draw_t, 28);

  // SplitMix64 running sum
  assign seed_start = (head.seed == 32'd0) ? 64'd1 : {32'd0, head.seed};
  assign seed_sum   = seed_start + GOLDEN_STEP;
  assign next_sum   = mix_sum + GOLDEN_STEP;

  // low 64 bits of x * const from three 32x32 partial products
  assign mul_const = mix_sel ? MIX_MUL_TWO : MIX_MUL_ONE;
  assign mul_a     = (mix_step == 2'd2) ? mix_x[63:32] : mix_x[31:0];
  assign mul_b     = (mix_step == 2'd1) ? mul_const[63:32] : mul_const[31:0];
  assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
  assign acc_sum   = (mix_step == 2'd0) ? mul_p : mix_acc + {mul_p[31:0], 32'd0};
  assign mix_mid   = acc_sum ^ (acc_sum >> 27);
  assign mix_res   = acc_sum ^ (acc_sum >> 31);
  assign last_step = (mix_step == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      word_a    <= RESET_A;
      word_b    <= RESET_B;
      mix_step  <= 2'd0;
      mix_sel   <= 1'b0;
      mix_word  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take_draw) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_draw) begin
            word_a <= draw_a;
            word_b <= draw_b;
          end else if (take_seed) begin
            mix_step <= 2'd0;
            mix_sel  <= 1'b0;
            mix_word <= 1'b0;
            state    <= ST_MIX;
          end
        end
        ST_MIX: begin
          mix_step <= last_step ? 2'd0 : mix_step + 2'd1;
          if (last_step) begin
            mix_sel <= ~mix_sel;
            if (mix_sel) begin
              if (!mix_word) begin
                word_a   <= mix_res;
                mix_word <= 1'b1;
              end else begin
                // force word b to one if both words came out zero
                word_b <= ((word_a | mix_res) == 64'd0) ? 64'd1 : mix_res;
                state  <= ST_IDLE;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_draw) begin
      value <= (head.kind == KIND_DRAW32) ? {21'd0, draw_out[31:0]}
                                          : draw_out[63:FRAC_SHIFT];
    end
    if (take_seed) begin
      mix_sum <= seed_sum;
      mix_x   <= seed_sum ^ (seed_sum >> 30);
    end else if (state == ST_MIX) begin
      mix_acc <= acc_sum;
      if (last_step && !mix_sel) begin
        mix_x <= mix_mid;
      end else if (last_step && !mix_word) begin
        mix_sum <= next_sum;
        mix_x   <= next_sum ^ (next_sum >> 30);
      end
    end
  end

`ifndef SYNTH
  a_seed_nonzero: assert property (@(posedge clk) disable iff (rst)
      (state == ST_MIX && last_step && mix_sel && mix_word) |=> (word_a | word_b) != 64'd0)
    else $error("state words all zero after reseed");
  a_draw_result: assert property (@(posedge clk) disable iff (rst) take_draw |=> res_valid)
    else $error("draw produced no result");
  a_step_range: assert property (@(posedge clk) disable iff (rst) mix_step != 2'd3)
    else $error("mix step out of range");
`endif

endmodule

/* tb/xoroshiro128pp_generator_checker.sv */
// Checker for the xoroshiro128++ generator: watches the command and result
// channels, keeps its own copy of the two state words and compares each draw.
// Depends on xoro_pkg for op codes, widths and the seeding constants.
`timescale 1ns / 100ps

module xoroshiro128pp_generator_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic [1:0]                   op,
  input  logic [31:0]                  seed,
  input  logic                         res_valid,
  input  logic                         res_stall,
  input  logic [xoro_pkg::VALUE_W-1:0] value,
  output int                           failures,
  output int                           pending
);
  import xoro_pkg::*;

  logic [63:0]        word_a;
  logic [63:0]        word_b;
  logic [VALUE_W-1:0] draw_values_q[$];

  function automatic logic [63:0] rot_word(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] splitmix_mix(input logic [63:0] sum);
    logic [63:0] z;
    z = sum;
    z = (z ^ (z >> 30)) * MIX_MUL_ONE;
    z = (z ^ (z >> 27)) * MIX_MUL_TWO;
    return z ^ (z >> 31);
  endfunction

  task automatic reseed_words(input logic [31:0] s);
    logic [63:0] sum;
    sum = (s == 32'd0) ? 64'd1 : {32'd0, s};
    sum = sum + GOLDEN_STEP;
    word_a = splitmix_mix(sum);
    sum = sum + GOLDEN_STEP;
    word_b = splitmix_mix(sum);
    if ((word_a | word_b) == 64'd0) word_b = 64'd1;
  endtask

  // Return the ++ output of the current state, then step the state.
  task automatic step_words(output logic [63:0] draw);
    logic [63:0] w1;
    draw = rot_word(word_a + word_b, 17) + word_a;
    w1 = word_b ^ word_a;
    word_a = rot_word(word_a, 49) ^ w1 ^ (w1 << 21);
    word_b = rot_word(w1, 28);
  endtask

  always @(posedge clk) begin
    logic [63:0]        draw;
    logic [VALUE_W-1:0] wanted;
    if (rst) begin
      word_a = RESET_A;
      word_b = RESET_B;
      draw_values_q.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        case (op)
          OP_RESEED: reseed_words(seed);
          OP_DRAW32: begin
            step_words(draw);
            draw_values_q.push_back({21'd0, draw[31:0]});
          end
          OP_DRAW53: begin
            step_words(draw);
            draw_values_q.push_back(draw[63:FRAC_SHIFT]);
          end
          default: ;  // unused op: no state change, no result
        endcase
      end
      if (res_valid && !res_stall) begin
        if (draw_values_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual value %h", $time, value);
        end else begin
          wanted = draw_values_q.pop_front();
          if (value !== wanted) begin
            failures++;
            $display("%0t: value mismatch, expected %h, actual %h", $time, wanted, value);
          end
        end
      end
    end
    pending = draw_values_q.size();
  end

endmodule

/* tb/xoroshiro128pp_generator_core_tb.sv */
// Top of the xoroshiro128++ generator bench: clock, reset, command stimulus
// and result-side stalls; the checker module does prediction and comparison.
// Depends on xoro_pkg, xoroshiro128pp_generator_core and the checker.
`timescale 1ns / 100ps

module xoroshiro128pp_generator_core_tb;
  import xoro_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = 20;

  logic               clk = 1'b0;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [1:0]         op;
  logic [31:0]        seed;
  logic               res_valid;
  logic               res_stall;
  logic [VALUE_W-1:0] value;
  int                 failures;
  int                 pending;
  bit                 hold_req = 1'b0;

  always #1 clk = ~clk;

  xoroshiro128pp_generator_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .op       (op),
    .seed     (seed),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .value    (value)
  );

  xoroshiro128pp_generator_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .op       (op),
    .seed     (seed),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .value    (value),
    .failures (failures),
    .pending  (pending)
  );

  // Offer one item at the current falling edge, hold it until accepted,
  // and return at the next falling edge.
  task automatic send_cmd(input logic [1:0] o, input logic [31:0] s);
    cmd_valid = 1'b1;
    op = o;
    seed = s;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return OP_RESEED;
    if (r < 14) return OP_NONE;
    if (r < 57) return OP_DRAW32;
    return OP_DRAW53;
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    logic [1:0] o;
    rst = 1'b1;
    cmd_valid = 1'b0;
    op = OP_NONE;
    seed = 32'd0;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Draws from the reset state, ignored op, zero seed versus seed one,
    // all-ones seed, back-to-back reseeds.
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_DRAW53, 32'hFFFF_FFFF);
    send_cmd(OP_NONE, $urandom);
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_RESEED, 32'd0);
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_DRAW53, 32'd0);
    send_cmd(OP_RESEED, 32'd1);
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_DRAW53, 32'd0);
    send_cmd(OP_RESEED, 32'hFFFF_FFFF);
    send_cmd(OP_DRAW53, 32'd0);
    send_cmd(OP_DRAW32, 32'hFFFF_FFFF);
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_RESEED, 32'h8000_0000);
    send_cmd(OP_RESEED, 32'h0000_0001);
    send_cmd(OP_DRAW53, 32'd0);
    send_cmd(OP_NONE, 32'hFFFF_FFFF);
    send_cmd(OP_DRAW32, 32'd0);
    send_cmd(OP_RESEED, $urandom);
    send_cmd(OP_DRAW53, 32'd0);
    cmd_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        o = pick_op();
        send_cmd(o, (o == OP_RESEED) ? pick_seed() : $urandom);
        if (o != OP_NONE) sent++;
      end
      if (!hold_req && sent >= 200) begin
        // Keep offering draws while the result side holds off.
        hold_req = 1'b1;
        repeat (40) begin
          send_cmd(($urandom_range(0, 1) == 0) ? OP_DRAW32 : OP_DRAW53, $urandom);
          sent++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (sent >= 350 && sent < 350 + burst) gap = -1;
      if (gap != 0) begin
        cmd_valid = 1'b0;
        if (gap < 0) begin
          while (pending != 0) @(negedge clk);
          @(negedge clk);
        end else begin
          repeat (gap) @(negedge clk);
        end
      end
    end

    cmd_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin : receiver
    int mode;
    int span;
    bit held;
    res_stall = 1'b0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          res_stall = 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0: res_stall = 1'b0;
            1: res_stall = ($urandom_range(0, 3) == 0);
            2: res_stall = ($urandom_range(0, 3) != 0);
            default: res_stall = ~res_stall;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

/* xoroshiro128pp_generator_core.f */
src/xoro_pkg.sv
src/xoro_front.sv
src/xoro_back.sv
src/xoroshiro128pp_generator_core.sv
tb/xoroshiro128pp_generator_checker.sv
tb/xoroshiro128pp_generator_core_tb.sv
